// ===== rtl/aavr_pkg.sv =====
package aavr_pkg;

    localparam int MaxStages = 32;
    localparam logic signed [31:0] Deg360 = 32'sd23592960;
    localparam logic signed [31:0] Deg270 = 32'sd17694720;
    localparam logic signed [31:0] Deg180 = 32'sd11796480;
    localparam logic signed [31:0] Deg90 = 32'sd5898240;
    localparam logic signed [32:0] OneQ30 = 33'sd1073741824;
    localparam logic signed [32:0] GainQ30 = 33'sd652032874;

    typedef logic signed [32:0] t_cq;
    typedef logic signed [33:0] t_zq;

    function automatic t_zq atan_q24(input logic [4:0] idx);
        logic [31:0] tab [MaxStages];
        tab = '{32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
                32'd60000934, 32'd30029717, 32'd15018523, 32'd7509720,
                32'd3754917, 32'd1877466, 32'd938734, 32'd469367, 32'd234684,
                32'd117342, 32'd58671, 32'd29335, 32'd14668, 32'd7334,
                32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115,
                32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0};
        return t_zq'({2'b00, tab[idx]});
    endfunction

endpackage

// ===== rtl/aavr_cordic.sv =====
module aavr_cordic
    import aavr_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_zq              i_z,
    input  logic             i_negc,
    output logic             o_valid,
    output logic             o_negc,
    output t_cq              o_x,
    output t_cq              o_y
);

    localparam int N = (STAGES > MaxStages) ? MaxStages : STAGES;

    t_cq  r_x [N+1];
    t_cq  r_y [N+1];
    t_zq  r_z [N+1];
    logic r_v [N+1];
    logic r_n [N+1];

    always_comb begin
        r_x[0] = GainQ30;
        r_y[0] = '0;
        r_z[0] = i_z;
        r_v[0] = i_valid;
        r_n[0] = i_negc;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        t_cq dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                r_n[i+1] <= r_n[i];
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - atan_q24(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + atan_q24(5'(i));
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_negc = r_n[N];
    assign o_x = r_x[N];
    assign o_y = r_y[N];

endmodule

// ===== rtl/axis_angle_vector_rotate.sv =====
// Rotate a Q16.16 vector about a Q2.14 axis by an angle in Q16.16 degrees.
// Slave channel s_axis carries vector, axis and angle in one word; master
// channel m_axis returns the rotated vector and a saturation flag.
// Pipeline: quotient estimate (constant reciprocal multiply), remainder,
// correction and fold, CORDIC_STAGES stages of CORDIC (capped at 32),
// then matrix build (M1, M2, M3) and matrix-vector product (M4, M5) with
// the output register.
// Throughput is one word per cycle while the receiver keeps up; the CORDIC
// stages and multipliers are fully pipelined.
// The whole pipeline advances whenever the output register is empty or
// being taken; when the receiver stalls with a full output register, every
// stage holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears every valid bit; data registers are not reset.
// No state is kept between words.
module axis_angle_vector_rotate
    import aavr_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg (lowest first)
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x, rot_y, rot_z (lowest first)
    output logic [95:0]  m_axis_tdata,
    // saturated
    output logic         m_axis_tuser
);

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // carry vector and axis alongside the angle path
    localparam int DL = ((CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES) + 3;
    logic [143:0] r_vd [DL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vd[0] <= s_axis_tdata[143:0];
            for (int i = 1; i < DL; i++) r_vd[i] <= r_vd[i-1];
        end
    end

    // stage A: quotient estimate q = floor(ang * 2^40/360Q16) approx
    logic signed [31:0] ang;
    assign ang = s_axis_tdata[175:144];
    logic r_va, r_vb, r_vc;
    logic signed [31:0] r_ang_a;
    logic signed [63:0] r_prod_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0;
        end else if (en) begin
            r_va <= s_axis_tvalid; r_vb <= r_va; r_vc <= r_vb;
        end
    end
    // reciprocal 2^40/23592960 = 46603.38; use 46604 (rounded up) and floor the product, fix by +-1 later
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_a <= ang;
            r_prod_a <= 64'(ang) * 64'sd46604;
        end
    end

    // stage B: remainder r = ang - q*360, then one correction
    logic signed [31:0] q_b;
    assign q_b = 32'(r_prod_a >>> 40);
    logic signed [33:0] r_rem_b;
    always_ff @(posedge i_clk) begin
        if (en) r_rem_b <= 34'(r_ang_a) - 34'(64'(q_b) * 64'(Deg360));
    end

    // stage C: correct into [0,360), fold
    logic signed [33:0] rc;
    logic signed [31:0] t_c;
    logic negc_c;
    always_comb begin
        rc = r_rem_b;
        if (rc < 0) rc = rc + 34'(Deg360);
        else if (rc >= 34'(Deg360)) rc = rc - 34'(Deg360);
        negc_c = 1'b0;
        if (rc >= 34'(Deg270)) t_c = 32'(rc - 34'(Deg360));
        else if (rc > 34'(Deg90)) begin
            t_c = 32'(34'(Deg180) - rc);
            negc_c = 1'b1;
        end else t_c = 32'(rc);
    end
    t_zq  r_z_c;
    logic r_negc_c;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z_c <= t_zq'(t_c) <<< 8;
            r_negc_c <= negc_c;
        end
    end

    logic cv, cnegc;
    t_cq  cx, cy;
    aavr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vc),
        .i_z(r_z_c), .i_negc(r_negc_c),
        .o_valid(cv), .o_negc(cnegc), .o_x(cx), .o_y(cy)
    );

    logic signed [31:0] vv [3];
    logic signed [15:0] aa [3];
    for (genvar k = 0; k < 3; k++) begin : g_unp
        assign vv[k] = r_vd[DL-1][32*k +: 32];
        assign aa[k] = r_vd[DL-1][96+16*k +: 16];
    end

    // M1: c, d, s, axis products
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_cq r_c1, r_s1;
    logic signed [33:0] r_d1;
    logic signed [31:0] r_aa1 [6];
    logic signed [31:0] r_v1d [3];
    logic signed [15:0] r_a1 [3];
    t_cq cc;
    assign cc = cnegc ? -cx : cx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= cc;
            r_s1 <= cy;
            r_d1 <= 34'(OneQ30) - 34'(cc);
            for (int k = 0; k < 3; k++) begin
                r_aa1[k] <= 32'(aa[k]) * 32'(aa[k]);
                r_v1d[k] <= vv[k];
                r_a1[k] <= aa[k];
            end
            r_aa1[3] <= 32'(aa[0]) * 32'(aa[1]);
            r_aa1[4] <= 32'(aa[0]) * 32'(aa[2]);
            r_aa1[5] <= 32'(aa[1]) * 32'(aa[2]);
        end
    end

    // M2: d*aa products and s*a*2^14 terms, c*2^28
    logic signed [65:0] r_dp2 [6];
    logic signed [63:0] r_sa2 [3];
    logic signed [63:0] r_c2;
    logic signed [31:0] r_v2d [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) r_dp2[k] <= 66'(r_d1) * 66'(r_aa1[k]);
            for (int k = 0; k < 3; k++) begin
                r_sa2[k] <= (64'(r_s1) * 64'(r_a1[k])) <<< 14;
                r_v2d[k] <= r_v1d[k];
            end
            r_c2 <= 64'(r_c1) <<< 28;
        end
    end

    // M3: sum and round entries to Q26
    function automatic logic signed [34:0] rnd26(input logic signed [66:0] e);
        logic signed [66:0] t;
        t = (e + 67'sd2147483648) >>> 32;
        return 35'(t);
    endfunction
    logic signed [34:0] r_m3 [9];
    logic signed [31:0] r_v3d [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3[0] <= rnd26(67'(r_c2) + 67'(r_dp2[0]));
            r_m3[4] <= rnd26(67'(r_c2) + 67'(r_dp2[1]));
            r_m3[8] <= rnd26(67'(r_c2) + 67'(r_dp2[2]));
            r_m3[1] <= rnd26(67'(r_dp2[3]) - 67'(r_sa2[2]));
            r_m3[3] <= rnd26(67'(r_dp2[3]) + 67'(r_sa2[2]));
            r_m3[2] <= rnd26(67'(r_dp2[4]) + 67'(r_sa2[1]));
            r_m3[6] <= rnd26(67'(r_dp2[4]) - 67'(r_sa2[1]));
            r_m3[5] <= rnd26(67'(r_dp2[5]) - 67'(r_sa2[0]));
            r_m3[7] <= rnd26(67'(r_dp2[5]) + 67'(r_sa2[0]));
            for (int k = 0; k < 3; k++) r_v3d[k] <= r_v2d[k];
        end
    end

    // M4: nine products
    logic signed [66:0] r_p4 [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) r_p4[k] <= 67'(r_m3[k]) * 67'(r_v3d[k % 3]);
        end
    end

    // M5: row sums, round to Q16
    logic signed [68:0] r_r5 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++)
                r_r5[k] <= (69'(r_p4[3*k]) + 69'(r_p4[3*k+1]) + 69'(r_p4[3*k+2])
                            + 69'sd33554432) >>> 26;
        end
    end

    // output register with clipping
    logic [31:0] clip [3];
    logic [2:0]  sat;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sat[k] = 1'b1;
            if (r_r5[k] > 69'sd2147483647) clip[k] = 32'h7fffffff;
            else if (r_r5[k] < -69'sd2147483648) clip[k] = 32'h80000000;
            else begin
                clip[k] = r_r5[k][31:0];
                sat[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            r_v1 <= cv; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
            m_axis_tvalid <= r_v5;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {clip[2], clip[1], clip[0]};
            m_axis_tuser <= |sat;
        end
    end

    // remainder estimate must land within one correction of range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (r_rem_b > -34'(Deg360)) && (r_rem_b < 34'(Deg360) * 2))
        else $error("angle reduction out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word lost on stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output register");

endmodule

// ===== test/aavr_checker.sv =====
`timescale 1ns / 100ps

// Watch both channels, predict each rotation, compare in order.
module aavr_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [175:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [95:0]  i_out_data,
    input  logic         i_out_sat,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        logic [31:0] rot_z;
        logic [31:0] rot_y;
        logic [31:0] rot_x;
        logic        sat;
    } t_rotated;

    localparam longint TURN = 23592960;
    localparam longint THREE_Q = 17694720;
    localparam longint HALF_TURN = 11796480;
    localparam longint QUARTER = 5898240;

    longint atan_deg [32] = '{754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720, 3754917, 1877466, 938734,
        469367, 234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    t_rotated rotations_due[$];

    function automatic longint to_q26(longint e);
        return (e + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function automatic t_rotated rotate(logic [175:0] w);
        longint v [3];
        longint a [3];
        longint m [3][3];
        longint ang, r, t, x, y, z, dx, dy, c, s, d, acc, q;
        logic negc;
        t_rotated res;
        logic [31:0] comp [3];
        res.sat = 1'b0;
        negc = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v[k] = longint'($signed(w[32*k +: 32]));
            a[k] = longint'($signed(w[96 + 16*k +: 16]));
        end
        ang = longint'($signed(w[175:144]));
        r = ang % TURN;
        if (r < 0) r += TURN;
        // fold into [-90, 90], flipping cosine for the back half
        if (r >= THREE_Q) begin
            t = r - TURN;
        end else if (r > QUARTER) begin
            t = HALF_TURN - r;
            negc = 1'b1;
        end else begin
            t = r;
        end
        x = 652032874;
        y = 0;
        z = t * 256;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_deg[i];
            end else begin
                x += dx; y -= dy; z += atan_deg[i];
            end
        end
        c = negc ? -x : x;
        s = y;
        d = 64'sd1073741824 - c;
        for (int k = 0; k < 3; k++)
            m[k][k] = to_q26(c * (64'sd1 <<< 28) + d * (a[k] * a[k]));
        m[0][1] = to_q26(d * (a[0] * a[1]) - s * a[2] * 16384);
        m[1][0] = to_q26(d * (a[0] * a[1]) + s * a[2] * 16384);
        m[0][2] = to_q26(d * (a[0] * a[2]) + s * a[1] * 16384);
        m[2][0] = to_q26(d * (a[0] * a[2]) - s * a[1] * 16384);
        m[1][2] = to_q26(d * (a[1] * a[2]) - s * a[0] * 16384);
        m[2][1] = to_q26(d * (a[1] * a[2]) + s * a[0] * 16384);
        for (int k = 0; k < 3; k++) begin
            acc = m[k][0] * v[0] + m[k][1] * v[1] + m[k][2] * v[2];
            q = (acc + (64'sd1 <<< 25)) >>> 26;
            if (q > 64'sd2147483647) begin
                q = 64'sd2147483647; res.sat = 1'b1;
            end else if (q < -64'sd2147483648) begin
                q = -64'sd2147483648; res.sat = 1'b1;
            end
            comp[k] = q[31:0];
        end
        res.rot_x = comp[0];
        res.rot_y = comp[1];
        res.rot_z = comp[2];
        return res;
    endfunction

    assign o_pending = rotations_due.size();

    always @(posedge i_clk) begin
        t_rotated want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                rotations_due.push_back(rotate(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (rotations_due.size() == 0) begin
                    $display("%0t: unexpected word %h sat %b", $time,
                             i_out_data, i_out_sat);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rotations_due.pop_front();
                    if (want.rot_x !== i_out_data[31:0] || want.rot_y !== i_out_data[63:32]
                        || want.rot_z !== i_out_data[95:64] || want.sat !== i_out_sat) begin
                        $display("%0t: expected x %h y %h z %h sat %b, got x %h y %h z %h sat %b",
                                 $time, want.rot_x, want.rot_y, want.rot_z, want.sat,
                                 i_out_data[31:0], i_out_data[63:32], i_out_data[95:64],
                                 i_out_sat);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 9;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 410;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;   // rot_x, rot_y, rot_z
    logic         m_axis_tuser;   // saturated

    int errors;
    int pending;
    int idle_pct;          // sender gap chance per cycle, in percent
    int stall_pct;         // receiver stall chance per cycle, in percent
    int hold_len = 0;      // length of the forced receiver stall, set by the stimulus
    int hold_seen = 0;     // last stall length the receiver picked up
    int hold_off = 0;      // cycles of forced receiver stall still to run
    int quiet_cycles = 0;

    axis_angle_vector_rotate #(.CORDIC_STAGES(STAGES)) u_dut (.*);

    aavr_checker #(.CORDIC_STAGES(STAGES)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_sat(m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: stall at random, or hold off entirely while hold_off runs.
    always @(negedge i_clk) begin
        if (hold_len != hold_seen) begin
            hold_seen <= hold_len;
            hold_off <= hold_len - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word, with random gaps before it; return once accepted.
    task automatic send_word(input logic [31:0] vx, vy, vz,
                             input logic [15:0] ax, ay, az,
                             input logic [31:0] ang);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ang, az, ay, ax, vz, vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_vec_comp();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(400 << 16)) - (200 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(720 << 16)) - (360 << 16));
            2: return 32'($signed($urandom_range(6)) * (90 << 16) - (270 << 16));
            default: return 32'($signed($urandom_range(4000 << 16)) - (2000 << 16));
        endcase
    endfunction

    // Mostly near-unit axes; now and then any 16-bit triple.
    task automatic send_random();
        real ux, uy, uz, len;
        logic [15:0] ax, ay, az;
        if ($urandom_range(3) == 0) begin
            ax = $urandom(); ay = $urandom(); az = $urandom();
        end else begin
            ux = $signed($urandom_range(2000)) - 1000.0;
            uy = $signed($urandom_range(2000)) - 1000.0;
            uz = $signed($urandom_range(2000)) - 1000.0;
            len = $sqrt(ux * ux + uy * uy + uz * uz);
            if (len < 1.0) begin
                ux = 1.0; uy = 0.0; uz = 0.0; len = 1.0;
            end
            ax = 16'($rtoi(ux / len * 16384.0));
            ay = 16'($rtoi(uy / len * 16384.0));
            az = 16'($rtoi(uz / len * 16384.0));
        end
        send_word(rand_vec_comp(), rand_vec_comp(), rand_vec_comp(), ax, ay, az, rand_angle());
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, quadrant boundaries, zero and oversized axes.
        send_word(32'h0001_0000, 0, 0, 16'h0000, 16'h0000, 16'h4000, 32'd0);
        send_word(32'h0001_0000, 0, 0, 16'h0000, 16'h0000, 16'h4000, 32'd90 << 16);
        send_word(32'h0001_0000, 0, 0, 16'h0000, 16'h0000, 16'h4000, 32'd180 << 16);
        send_word(32'h0001_0000, 0, 0, 16'h0000, 16'h0000, 16'h4000, 32'd270 << 16);
        send_word(0, 32'h0001_0000, 0, 16'h4000, 16'h0000, 16'h0000, 32'd360 << 16);
        send_word(0, 0, 32'h0001_0000, 16'h0000, 16'h4000, 16'h0000, -(32'd90 << 16));
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h0000, 16'h0000, 16'h0000, 32'd45 << 16);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  16'h0000, 16'h0000, 16'h0000, 32'd0);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);
        send_word(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000,
                  16'h2000, 16'h8000, 16'h7FFF, 32'd123 << 16);
        send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  16'h24F3, 16'h24F3, 16'h24F3, (32'd90 << 16) - 1);
        send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  16'h24F3, 16'h24F3, 16'h24F3, (32'd270 << 16) + 1);
        send_word(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                  16'hFFFF, 16'h0001, 16'h5555, 32'hAAAA_AAAA);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                  16'hAAAA, 16'hFFFF, 16'h0001, 32'h5555_5555);

        // Phase: no idling, but one long receiver hold while words keep coming.
        hold_len = 300;
        repeat (RANDOM_PER_PHASE) send_random();
        idle_pct = 79;
        stall_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random();
        idle_pct = 0;
        stall_pct = 79;
        repeat (RANDOM_PER_PHASE) send_random();
        idle_pct = 38;
        stall_pct = 38;
        repeat (RANDOM_PER_PHASE) send_random();
        s_axis_tvalid <= 1'b0;

        // Drain; the watchdog covers a lost word.
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/aavr_pkg.sv
rtl/aavr_cordic.sv
rtl/axis_angle_vector_rotate.sv
test/aavr_checker.sv
test/tb_top.sv
